### hw/rtl/smc_pkg.sv
// shared types and constants of the stepper axis motion controller
// used by smc_cfg, smc_core and stepper_axis_motion_controller
`timescale 1ns / 1ps

package smc_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_STEPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEPS = 2'd2;

  localparam logic [CFG_W-1:0] STEP_PERIOD_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] TRAVEL_STEPS_RST  = 16'd2000;
  localparam logic [CFG_W-1:0] BACKOFF_STEPS_RST = 16'd500;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_DOWN    = 3'd1,
    MODE_UP      = 3'd2,
    MODE_EMERG   = 3'd3,
    MODE_BACKOFF = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_DESCEND = 3'd0,
    CMD_ASCEND  = 3'd1,
    CMD_MOVE    = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RESET   = 3'd4,
    CMD_HOME    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BUSY     = 3'd1,
    ERR_EMERG    = 3'd2,
    ERR_NOT_HOME = 3'd3,
    ERR_RANGE    = 3'd4
  } err_e;

  typedef struct packed {
    logic [CFG_W-1:0] step_period;
    logic [CFG_W-1:0] travel_steps;
    logic [CFG_W-1:0] backoff_steps;
  } cfg_t;

  typedef struct packed {
    logic  step_strobe;
    logic  direction_up;
    logic  motor_enable;
    mode_e mode;
    err_e  error;
  } status_t;

endpackage

### hw/rtl/smc_cfg.sv
// configuration register file of the stepper axis motion controller
// depends on smc_pkg
`timescale 1ns / 1ps

module smc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [smc_pkg::CFG_W-1:0]   cfg_data_i,
  output smc_pkg::cfg_t               cfg_o
);

  smc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period   <= smc_pkg::STEP_PERIOD_RST;
      cfg_q.travel_steps  <= smc_pkg::TRAVEL_STEPS_RST;
      cfg_q.backoff_steps <= smc_pkg::BACKOFF_STEPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        smc_pkg::CFG_STEP_PERIOD:   cfg_q.step_period   <= cfg_data_i;
        smc_pkg::CFG_TRAVEL_STEPS:  cfg_q.travel_steps  <= cfg_data_i;
        smc_pkg::CFG_BACKOFF_STEPS: cfg_q.backoff_steps <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/smc_core.sv
// motion state and next-state logic of the stepper axis motion controller
// depends on smc_pkg
`timescale 1ns / 1ps

module smc_core #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned PERIOD_WIDTH   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      kind_i,
  input  logic [2:0]                command_i,
  input  logic [POSITION_WIDTH-1:0] target_steps_i,
  input  logic                      limit_pressed_i,
  input  smc_pkg::cfg_t             cfg_i,
  output smc_pkg::status_t          status_o,
  output logic [POSITION_WIDTH-1:0] position_o
);

  localparam int unsigned StepW =
    (POSITION_WIDTH > smc_pkg::CFG_W) ? POSITION_WIDTH : smc_pkg::CFG_W;
  localparam int unsigned RelW =
    (PERIOD_WIDTH > smc_pkg::CFG_W) ? PERIOD_WIDTH : smc_pkg::CFG_W;

  smc_pkg::mode_e            mode_q, mode_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [StepW-1:0]          steps_q, steps_d;
  logic [PERIOD_WIDTH-1:0]   per_q, per_d;
  logic                      up_q, up_d;
  logic                      seek_q, seek_d;
  logic                      strobe;
  smc_pkg::err_e             err;
  logic                      active;
  logic [smc_pkg::CFG_W-1:0] period_eff;
  logic [RelW-1:0]           reload_wide;
  logic [PERIOD_WIDTH-1:0]   reload;
  logic [StepW-1:0]          target_x, travel_x, pos_x;

  // zero period acts as one
  assign period_eff  = (cfg_i.step_period == '0) ? smc_pkg::CFG_W'(1) : cfg_i.step_period;
  assign reload_wide = RelW'(period_eff - smc_pkg::CFG_W'(1));
  assign reload      = reload_wide[PERIOD_WIDTH-1:0];

  assign target_x = StepW'(target_steps_i);
  assign travel_x = StepW'(cfg_i.travel_steps);
  assign pos_x    = StepW'(pos_q);

  assign active = (mode_q == smc_pkg::MODE_DOWN) || (mode_q == smc_pkg::MODE_UP) ||
                  (mode_q == smc_pkg::MODE_BACKOFF);

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    steps_d = steps_q;
    per_d   = per_q;
    up_d    = up_q;
    seek_d  = seek_q;
    strobe  = 1'b0;
    err     = smc_pkg::ERR_NONE;
    if (!kind_i) begin
      if (active) begin
        if (up_q && limit_pressed_i) begin
          if (seek_q) begin
            pos_d = '0;
          end
          mode_d  = smc_pkg::MODE_IDLE;
          seek_d  = 1'b0;
          steps_d = '0;
          per_d   = '0;
        end else if (per_q != '0) begin
          per_d = per_q - PERIOD_WIDTH'(1);
        end else if (!seek_q && steps_q == '0) begin
          // steps done: a backoff turns around and seeks the switch, other moves go idle
          if (mode_q == smc_pkg::MODE_BACKOFF) begin
            mode_d = smc_pkg::MODE_UP;
            up_d   = 1'b1;
            seek_d = 1'b1;
          end else begin
            mode_d = smc_pkg::MODE_IDLE;
            seek_d = 1'b0;
          end
          steps_d = '0;
          per_d   = '0;
        end else begin
          strobe = 1'b1;
          if (up_q) begin
            if (pos_q != '0) begin
              pos_d = pos_q - POSITION_WIDTH'(1);
            end
          end else if (pos_q != '1) begin
            pos_d = pos_q + POSITION_WIDTH'(1);
          end
          if (!seek_q && steps_q != '0) begin
            steps_d = steps_q - StepW'(1);
          end
          per_d = reload;
        end
      end
    end else begin
      case (command_i)
        smc_pkg::CMD_STOP: begin
          mode_d  = smc_pkg::MODE_EMERG;
          seek_d  = 1'b0;
          steps_d = '0;
          per_d   = '0;
        end
        smc_pkg::CMD_RESET: begin
          mode_d  = smc_pkg::MODE_IDLE;
          seek_d  = 1'b0;
          steps_d = '0;
          per_d   = '0;
        end
        smc_pkg::CMD_DESCEND, smc_pkg::CMD_ASCEND, smc_pkg::CMD_MOVE,
        smc_pkg::CMD_HOME: begin
          if (mode_q == smc_pkg::MODE_EMERG) begin
            err = smc_pkg::ERR_EMERG;
          end else if (mode_q != smc_pkg::MODE_IDLE) begin
            err = smc_pkg::ERR_BUSY;
          end else begin
            case (command_i)
              smc_pkg::CMD_DESCEND: begin
                if (!limit_pressed_i) begin
                  err = smc_pkg::ERR_NOT_HOME;
                end else begin
                  pos_d = '0;
                  up_d  = 1'b0;
                  if (cfg_i.travel_steps != '0) begin
                    mode_d  = smc_pkg::MODE_DOWN;
                    seek_d  = 1'b0;
                    steps_d = travel_x;
                    per_d   = '0;
                  end
                end
              end
              smc_pkg::CMD_ASCEND: begin
                up_d = 1'b1;
                if (limit_pressed_i) begin
                  pos_d = '0;
                end else begin
                  mode_d  = smc_pkg::MODE_UP;
                  seek_d  = 1'b1;
                  steps_d = '0;
                  per_d   = '0;
                end
              end
              smc_pkg::CMD_MOVE: begin
                if (target_x > travel_x) begin
                  err = smc_pkg::ERR_RANGE;
                end else if (target_x > pos_x) begin
                  mode_d  = smc_pkg::MODE_DOWN;
                  up_d    = 1'b0;
                  seek_d  = 1'b0;
                  steps_d = target_x - pos_x;
                  per_d   = '0;
                end else if (target_x < pos_x) begin
                  mode_d  = smc_pkg::MODE_UP;
                  up_d    = 1'b1;
                  seek_d  = 1'b0;
                  steps_d = pos_x - target_x;
                  per_d   = '0;
                end
              end
              default: begin
                // home: release the switch first when it is pressed and backoff_steps is nonzero, else seek it upward
                per_d = '0;
                if (limit_pressed_i && cfg_i.backoff_steps != '0) begin
                  mode_d  = smc_pkg::MODE_BACKOFF;
                  up_d    = 1'b0;
                  seek_d  = 1'b0;
                  steps_d = StepW'(cfg_i.backoff_steps);
                end else begin
                  mode_d  = smc_pkg::MODE_UP;
                  up_d    = 1'b1;
                  seek_d  = 1'b1;
                  steps_d = '0;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= smc_pkg::MODE_IDLE;
      pos_q   <= '0;
      steps_q <= '0;
      per_q   <= '0;
      up_q    <= 1'b0;
      seek_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      steps_q <= steps_d;
      per_q   <= per_d;
      up_q    <= up_d;
      seek_q  <= seek_d;
    end
  end

  assign status_o.step_strobe  = strobe;
  assign status_o.direction_up = up_d;
  assign status_o.motor_enable = (mode_d == smc_pkg::MODE_DOWN) ||
                                 (mode_d == smc_pkg::MODE_UP) ||
                                 (mode_d == smc_pkg::MODE_BACKOFF);
  assign status_o.mode         = mode_d;
  assign status_o.error        = err;
  assign position_o            = pos_d;

  // a step only comes out of a running motion
  a_step_needs_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && strobe |-> active && !kind_i)
    else $error("step strobe outside a running motion");

  // each step reloads the period counter
  a_step_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && strobe |=> per_q == $past(reload))
    else $error("period counter not reloaded after a step");

  // a limit seek always runs upward
  a_seek_is_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seek_q |-> up_q)
    else $error("limit seek without upward direction");

  // stopped modes carry no leftover motion
  a_stopped_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == smc_pkg::MODE_IDLE || mode_q == smc_pkg::MODE_EMERG)
      |-> per_q == '0 && steps_q == '0 && !seek_q)
    else $error("stopped mode holds motion state");

endmodule

### hw/rtl/stepper_axis_motion_controller.sv
// top level of the stepper axis motion controller: input and result registers
// depends on smc_pkg, smc_cfg and smc_core
`timescale 1ns / 1ps

// step/direction controller for one leadscrew axis with an upper limit switch
// input channel: in_valid_i / in_stall_o, one transfer per item; an item is a
//   one-microsecond tick (kind 0) or a command (kind 1), and every item
//   carries the current level of the limit switch
// result channel: out_valid_o / out_stall_i, exactly one result transfer per
//   input item, in order: step strobe, direction, driver enable, mode,
//   position in steps below the limit and an error code
// configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 step period, 1 travel, 2 backoff); write only while the block is idle
// path: an accepted item waits in the input register; its result is
//   registered in the result register and shown from then on until taken
// throughput: one item per cycle unless the result channel stalls, set by the
//   single pass of next-state logic between the input and result registers
// stall: when the result waits, the input register holds and in_stall_o rises
//   only once that register is full, so one further item is still taken
// reset: asynchronous, active low; the axis comes up idle at position 0 with
//   the default period, travel and backoff; both channels come up empty
module stepper_axis_motion_controller #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned PERIOD_WIDTH   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [smc_pkg::CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [2:0]                    command_i,
  input  logic [POSITION_WIDTH-1:0]     target_steps_i,
  input  logic                          limit_pressed_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          step_strobe_o,
  output logic                          direction_up_o,
  output logic                          motor_enable_o,
  output logic [2:0]                    mode_o,
  output logic [POSITION_WIDTH-1:0]     position_o,
  output logic [2:0]                    error_o
);

  smc_pkg::cfg_t             cfg;
  smc_pkg::status_t          status;
  logic [POSITION_WIDTH-1:0] position;

  // input register
  logic                      in_vld_q;
  logic                      kind_q;
  logic [2:0]                command_q;
  logic [POSITION_WIDTH-1:0] target_q;
  logic                      limit_q;

  // result register
  logic                      out_vld_q;
  smc_pkg::status_t          status_q;
  logic [POSITION_WIDTH-1:0] position_q;

  logic out_free;
  logic fire;
  logic in_xfer;

  // result register can take a new value when empty or being drained
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  smc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  smc_core #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .PERIOD_WIDTH   (PERIOD_WIDTH)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .kind_i          (kind_q),
    .command_i       (command_q),
    .target_steps_i  (target_q),
    .limit_pressed_i (limit_q),
    .cfg_i           (cfg),
    .status_o        (status),
    .position_o      (position)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q    <= kind_i;
      command_q <= command_i;
      target_q  <= target_steps_i;
      limit_q   <= limit_pressed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q   <= status;
      position_q <= position;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign step_strobe_o  = status_q.step_strobe;
  assign direction_up_o = status_q.direction_up;
  assign motor_enable_o = status_q.motor_enable;
  assign mode_o         = status_q.mode;
  assign error_o        = status_q.error;
  assign position_o     = position_q;

endmodule
